// ===== design/psbb_pkg.sv =====
// Shared types, constants and helpers of the polar scan bounding box core.
// Used by every design file through scoped names; depends on nothing else.
package psbb_pkg;

  // Field and quantization widths
  localparam int ANGLE_BITS = 16;
  localparam int RANGE_BITS = 24;
  localparam int HEAD_W     = 16;
  localparam int ANGLE_DROP = (ANGLE_BITS < HEAD_W) ? (HEAD_W - ANGLE_BITS) : 0;
  localparam logic [HEAD_W-1:0] HEAD_MASK = 16'hFFFF << ANGLE_DROP;
  localparam logic [HEAD_W-1:0] QUARTER_TURN = 16'h4000;

  localparam int IN_DATA_W  = ((RANGE_BITS + 7) / 8) * 8;
  localparam int COORD_W    = 32;
  localparam int OUT_DATA_W = 4 * COORD_W;
  localparam int PAD_W      = 20;

  // Sine polynomial datapath widths
  localparam int U_W    = 15;                  // quarter-wave index 0..16384
  localparam int X2_W   = 31;                  // x^2 in Q30
  localparam int T_W    = 31;                  // Horner term in Q30
  localparam int MAG_W  = 17;                  // magnitude 0..65536
  localparam int PROD_W = RANGE_BITS + MAG_W;  // range times magnitude
  localparam int ACC_W  = PROD_W + 1;          // lane working value
  localparam int OFS_W  = ACC_W - 16;          // rounded offset magnitude
  localparam int SUM_W  = ((OFS_W > COORD_W) ? OFS_W : COORD_W) + 1;

  localparam logic [U_W-1:0]   QUARTER = 15'd16384;
  localparam logic [MAG_W-1:0] MAG_MAX = 17'd65536;

  // Degree-9 sine series coefficients in Q30
  localparam logic [T_W-1:0] POLY_C9 = 31'd172272;
  localparam logic [T_W-1:0] HORNER_C [4] = '{
    31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
  };

  // Back-end pipeline stage indexes
  localparam int STG_SQ    = 1;
  localparam int STG_H0    = 2;
  localparam int STG_MAG   = 6;
  localparam int STG_SCALE = 7;
  localparam int STG_POINT = 8;
  localparam int NPIPE     = 9;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_X        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_Y        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_HEADING = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PADDING       = 3'd4;
  localparam logic [PAD_W-1:0]     PADDING_RESET     = 20'd32768;

  typedef struct packed {
    logic signed [COORD_W-1:0] base_x;
    logic signed [COORD_W-1:0] base_y;
    logic [HEAD_W-1:0]         start_heading;
    logic [HEAD_W-1:0]         angle_step;
    logic [PAD_W-1:0]          padding;
  } psbb_cfg_t;

  // Classified sample as it travels through the queue
  typedef struct packed {
    logic [RANGE_BITS-1:0] range;
    logic                  last;
    logic                  first;
    logic [HEAD_W-1:0]     heading;
  } psbb_item_t;

  typedef struct packed {
    logic [RANGE_BITS-1:0] range;
    logic                  last;
    logic                  first;
  } psbb_meta_t;

  // One trig lane (x uses cosine, y uses sine)
  typedef struct packed {
    logic [U_W-1:0]   u;
    logic             neg;
    logic [X2_W-1:0]  x2;
    logic [ACC_W-1:0] acc;
  } psbb_lane_t;

  // Fold a binary angle into a quarter-wave index and a sign
  function automatic psbb_lane_t lane_seed(input logic [HEAD_W-1:0] h);
    psbb_lane_t     ln;
    logic [U_W-1:0] frac;
    frac   = {1'b0, h[13:0]};
    ln     = '0;
    ln.neg = h[15];
    ln.u   = h[14] ? (QUARTER - frac) : frac;
    return ln;
  endfunction

  // Clamp a wide signed value to the coordinate range
  function automatic logic signed [COORD_W-1:0] sat_coord(
    input logic signed [SUM_W-1:0] v
  );
    logic [SUM_W-COORD_W:0] top;
    top = v[SUM_W-1:COORD_W-1];
    if ((&top) || (~|top)) begin
      return v[COORD_W-1:0];
    end
    return v[SUM_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

endpackage

// ===== design/psbb_front.sv =====
// Front end: accepts range samples, tracks scan start and running heading.
// Depends on psbb_pkg; feeds psbb_queue.
module psbb_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  psbb_pkg::psbb_cfg_t             cfg_i,
  input  logic                            s_valid_i,
  input  logic [psbb_pkg::IN_DATA_W-1:0]  s_data_i,
  input  logic                            s_last_i,
  output logic                            s_ready_o,
  input  logic                            q_ready_i,
  output logic                            push_o,
  output psbb_pkg::psbb_item_t            item_o
);

  logic                         open_q, open_d;
  logic [psbb_pkg::HEAD_W-1:0]  head_q, head_d;
  logic [psbb_pkg::HEAD_W-1:0]  head_cur;

  assign s_ready_o = q_ready_i;
  assign push_o    = s_valid_i & q_ready_i;

  // Pick heading: load start heading when a scan opens
  always_comb begin
    head_cur       = open_q ? head_q : cfg_i.start_heading;
    item_o.range   = s_data_i[psbb_pkg::RANGE_BITS-1:0];
    item_o.last    = s_last_i;
    item_o.first   = ~open_q;
    item_o.heading = head_cur & psbb_pkg::HEAD_MASK;
    head_d         = head_q;
    open_d         = open_q;
    if (push_o) begin
      head_d = head_cur + cfg_i.angle_step;
      open_d = ~s_last_i;
    end
  end

  // Hold scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      head_q <= '0;
    end else begin
      open_q <= open_d;
      head_q <= head_d;
    end
  end

endmodule

// ===== design/psbb_queue.sv =====
// Short FIFO of classified items between front and back end.
// Depends on psbb_pkg for the item type and depth.
module psbb_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  psbb_pkg::psbb_item_t item_i,
  output logic                 ready_o,
  output logic                 valid_o,
  output psbb_pkg::psbb_item_t item_o,
  input  logic                 pop_i
);

  psbb_pkg::psbb_item_t           mem_q [psbb_pkg::QDEPTH];
  logic [psbb_pkg::QPTR_W-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [psbb_pkg::QCNT_W-1:0]    cnt_q, cnt_d;

  assign ready_o = (cnt_q != psbb_pkg::QCNT_W'(psbb_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];

  // Advance pointers and count
  always_comb begin
    wr_d  = push_i ? (wr_q + 1'b1) : wr_q;
    rd_d  = pop_i ? (rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// ===== design/psbb_back.sv =====
// Back end: sine/cosine series, range scaling, point, box tracking, padding.
// Depends on psbb_pkg; drains psbb_queue and drives the result register.
module psbb_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  psbb_pkg::psbb_cfg_t             cfg_i,
  input  logic                            in_valid_i,
  input  psbb_pkg::psbb_item_t            item_i,
  output logic                            in_pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [psbb_pkg::OUT_DATA_W-1:0] out_data_o
);

  logic                           stall;
  logic [psbb_pkg::NPIPE-1:0]     valid_q;
  psbb_pkg::psbb_meta_t           meta_q [psbb_pkg::NPIPE];
  psbb_pkg::psbb_lane_t           lane_q [psbb_pkg::NPIPE][2];
  psbb_pkg::psbb_lane_t           lane_d [psbb_pkg::NPIPE][2];

  logic signed [psbb_pkg::COORD_W-1:0] lo_q  [2];
  logic signed [psbb_pkg::COORD_W-1:0] hi_q  [2];
  logic signed [psbb_pkg::COORD_W-1:0] lo_d  [2];
  logic signed [psbb_pkg::COORD_W-1:0] hi_d  [2];
  logic signed [psbb_pkg::COORD_W-1:0] fin_lo_q [2];
  logic signed [psbb_pkg::COORD_W-1:0] fin_hi_q [2];
  logic signed [psbb_pkg::COORD_W-1:0] pad_lo [2];
  logic signed [psbb_pkg::COORD_W-1:0] pad_hi [2];
  logic                                fin_v_q;
  logic                                out_valid_q;
  logic [psbb_pkg::OUT_DATA_W-1:0]     out_data_q;

  // Freeze every stage while a result waits on the output
  assign stall       = out_valid_q & ~out_ready_i;
  assign in_pop_o    = in_valid_i & ~stall;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Lane datapath, one operation per stage
  always_comb begin
    logic [2*psbb_pkg::U_W-1:0]             sq;
    logic [psbb_pkg::X2_W+psbb_pkg::T_W-1:0] hp;
    logic [psbb_pkg::T_W:0]                 tn;
    logic [psbb_pkg::U_W+psbb_pkg::T_W-1:0] mt;
    logic [32:0]                            rq;
    logic [18:0]                            mg;
    logic [psbb_pkg::PROD_W-1:0]            pr;
    logic [psbb_pkg::ACC_W-1:0]             rs;
    logic [psbb_pkg::OFS_W-1:0]             ofs;
    logic signed [psbb_pkg::SUM_W-1:0]      ofs_s;
    logic signed [psbb_pkg::SUM_W-1:0]      base_s;
    logic signed [psbb_pkg::COORD_W-1:0]    pt;
    for (int l = 0; l < 2; l++) begin
      // Fold heading into quarter wave; lane 0 takes cosine
      lane_d[0][l] = psbb_pkg::lane_seed((l == 0) ?
                       (item_i.heading + psbb_pkg::QUARTER_TURN) : item_i.heading);

      // Square the index: x^2 in Q30 is u*u shifted by two
      lane_d[psbb_pkg::STG_SQ][l]     = lane_q[0][l];
      sq                               = lane_q[0][l].u * lane_q[0][l].u;
      lane_d[psbb_pkg::STG_SQ][l].x2  = psbb_pkg::X2_W'({sq, 2'b00});
      lane_d[psbb_pkg::STG_SQ][l].acc = psbb_pkg::ACC_W'(psbb_pkg::POLY_C9);

      // Horner steps of the odd series
      for (int k = 0; k < 4; k++) begin
        lane_d[psbb_pkg::STG_H0+k][l] = lane_q[psbb_pkg::STG_H0+k-1][l];
        hp = lane_q[psbb_pkg::STG_H0+k-1][l].x2 *
             lane_q[psbb_pkg::STG_H0+k-1][l].acc[psbb_pkg::T_W-1:0];
        tn = {1'b0, psbb_pkg::HORNER_C[k]} - hp[psbb_pkg::X2_W+psbb_pkg::T_W-1:30];
        lane_d[psbb_pkg::STG_H0+k][l].acc = psbb_pkg::ACC_W'(tn[psbb_pkg::T_W-1:0]);
      end

      // Final multiply by x, round to Q16 and cap at one
      lane_d[psbb_pkg::STG_MAG][l] = lane_q[psbb_pkg::STG_MAG-1][l];
      mt = lane_q[psbb_pkg::STG_MAG-1][l].u *
           lane_q[psbb_pkg::STG_MAG-1][l].acc[psbb_pkg::T_W-1:0];
      rq = {1'b0, mt[psbb_pkg::U_W+psbb_pkg::T_W-1:14]} + 33'd8192;
      mg = rq[32:14];
      lane_d[psbb_pkg::STG_MAG][l].acc = (mg > 19'd65536) ?
        psbb_pkg::ACC_W'(psbb_pkg::MAG_MAX) : psbb_pkg::ACC_W'(mg[psbb_pkg::MAG_W-1:0]);

      // Scale magnitude by range
      lane_d[psbb_pkg::STG_SCALE][l] = lane_q[psbb_pkg::STG_SCALE-1][l];
      pr = meta_q[psbb_pkg::STG_SCALE-1].range *
           lane_q[psbb_pkg::STG_SCALE-1][l].acc[psbb_pkg::MAG_W-1:0];
      lane_d[psbb_pkg::STG_SCALE][l].acc = {1'b0, pr};

      // Round half away from zero, apply sign, add base, saturate
      lane_d[psbb_pkg::STG_POINT][l] = lane_q[psbb_pkg::STG_POINT-1][l];
      rs     = lane_q[psbb_pkg::STG_POINT-1][l].acc + psbb_pkg::ACC_W'(32768);
      ofs    = rs[psbb_pkg::ACC_W-1:16];
      ofs_s  = psbb_pkg::SUM_W'($signed(ofs));
      if (lane_q[psbb_pkg::STG_POINT-1][l].neg) begin
        ofs_s = -ofs_s;
      end
      base_s = (l == 0) ? psbb_pkg::SUM_W'(cfg_i.base_x) : psbb_pkg::SUM_W'(cfg_i.base_y);
      pt     = psbb_pkg::sat_coord(base_s + ofs_s);
      lane_d[psbb_pkg::STG_POINT][l].acc = psbb_pkg::ACC_W'(pt);
    end
  end

  // Update box: reload from base when a scan opens
  always_comb begin
    logic signed [psbb_pkg::COORD_W-1:0] p;
    logic signed [psbb_pkg::COORD_W-1:0] b;
    logic signed [psbb_pkg::COORD_W-1:0] lo_c;
    logic signed [psbb_pkg::COORD_W-1:0] hi_c;
    for (int l = 0; l < 2; l++) begin
      p     = $signed(lane_q[psbb_pkg::NPIPE-1][l].acc[psbb_pkg::COORD_W-1:0]);
      b     = (l == 0) ? cfg_i.base_x : cfg_i.base_y;
      lo_c  = meta_q[psbb_pkg::NPIPE-1].first ? b : lo_q[l];
      hi_c  = meta_q[psbb_pkg::NPIPE-1].first ? b : hi_q[l];
      lo_d[l] = (p < lo_c) ? p : lo_c;
      hi_d[l] = (p > hi_c) ? p : hi_c;
    end
  end

  // Widen finished box by padding
  always_comb begin
    logic signed [psbb_pkg::SUM_W-1:0] pad_s;
    logic signed [psbb_pkg::SUM_W-1:0] lo_s;
    logic signed [psbb_pkg::SUM_W-1:0] hi_s;
    pad_s = psbb_pkg::SUM_W'(cfg_i.padding);
    for (int l = 0; l < 2; l++) begin
      lo_s      = psbb_pkg::SUM_W'(fin_lo_q[l]);
      hi_s      = psbb_pkg::SUM_W'(fin_hi_q[l]);
      pad_lo[l] = psbb_pkg::sat_coord(lo_s - pad_s);
      pad_hi[l] = psbb_pkg::sat_coord(hi_s + pad_s);
    end
  end

  // Control: stage valids and result flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      fin_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (!stall) begin
      valid_q     <= {valid_q[psbb_pkg::NPIPE-2:0], in_pop_o};
      fin_v_q     <= valid_q[psbb_pkg::NPIPE-1] & meta_q[psbb_pkg::NPIPE-1].last;
      out_valid_q <= fin_v_q;
    end
  end

  // Payload: advance stages, box and result
  always_ff @(posedge clk_i) begin
    if (!stall) begin
      meta_q[0] <= '{range: item_i.range, last: item_i.last, first: item_i.first};
      for (int k = 1; k < psbb_pkg::NPIPE; k++) begin
        meta_q[k] <= meta_q[k-1];
      end
      for (int k = 0; k < psbb_pkg::NPIPE; k++) begin
        for (int l = 0; l < 2; l++) begin
          lane_q[k][l] <= lane_d[k][l];
        end
      end
      for (int l = 0; l < 2; l++) begin
        if (valid_q[psbb_pkg::NPIPE-1]) begin
          lo_q[l] <= lo_d[l];
          hi_q[l] <= hi_d[l];
        end
        fin_lo_q[l] <= lo_d[l];
        fin_hi_q[l] <= hi_d[l];
      end
      out_data_q <= {pad_hi[1], pad_lo[1], pad_hi[0], pad_lo[0]};
    end
  end

endmodule

// ===== design/polar_scan_bounding_box_core.sv =====
// Top level of the polar scan bounding box core: config registers, front end,
// queue and back end. Depends on psbb_pkg, psbb_front, psbb_queue, psbb_back.
//
//  channel   direction  handshake              payload
//  s_axis    in         tvalid/tready          tdata[23:0] range_sample, tlast last_sample
//  m_axis    out        tvalid/tready          tdata box_min_x..box_max_y (32 bits each)
//  cfg       in         cfg_we_i, no wait      cfg_idx_i register, cfg_wdata_i value
//
// One sample per cycle sustained while m_axis does not stall; the trig series, scaling
// and point sum run as a nine-stage multiplier pipeline followed by box and padding stages.
// A box reaches m_axis through the queue, the pipeline, the box stage and the padding stage.
// Reset clears the scan state; padding resets to 0.5 m, other registers to zero.
// A stalled result freezes the back end; the four-entry queue keeps s_axis
// open until it fills.
module polar_scan_bounding_box_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [psbb_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // [23:0] range_sample
  input  logic                              s_axis_tlast,   // last_sample
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [31:0] box_min_x, [63:32] box_max_x, [95:64] box_min_y, [127:96] box_max_y
  output logic [psbb_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [psbb_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [psbb_pkg::COORD_W-1:0]      cfg_wdata_i
);

  psbb_pkg::psbb_cfg_t  cfg_q, cfg_d;
  psbb_pkg::psbb_item_t front_item, queue_item;
  logic                 q_ready, q_push, q_valid, q_pop;

  // Decode register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        psbb_pkg::REG_BASE_X:        cfg_d.base_x        = $signed(cfg_wdata_i);
        psbb_pkg::REG_BASE_Y:        cfg_d.base_y        = $signed(cfg_wdata_i);
        psbb_pkg::REG_START_HEADING: cfg_d.start_heading = cfg_wdata_i[psbb_pkg::HEAD_W-1:0];
        psbb_pkg::REG_ANGLE_STEP:    cfg_d.angle_step    = cfg_wdata_i[psbb_pkg::HEAD_W-1:0];
        psbb_pkg::REG_PADDING:       cfg_d.padding       = cfg_wdata_i[psbb_pkg::PAD_W-1:0];
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_x        <= '0;
      cfg_q.base_y        <= '0;
      cfg_q.start_heading <= '0;
      cfg_q.angle_step    <= '0;
      cfg_q.padding       <= psbb_pkg::PADDING_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  psbb_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .s_valid_i (s_axis_tvalid),
    .s_data_i  (s_axis_tdata),
    .s_last_i  (s_axis_tlast),
    .s_ready_o (s_axis_tready),
    .q_ready_i (q_ready),
    .push_o    (q_push),
    .item_o    (front_item)
  );

  psbb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (front_item),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .item_o  (queue_item),
    .pop_i   (q_pop)
  );

  psbb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (q_valid),
    .item_i      (queue_item),
    .in_pop_o    (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ===== design/psbb_checker.sv =====
// Port-level checker for polar_scan_bounding_box_core, bound to the top level.
// Depends on psbb_pkg for port widths.
module psbb_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            s_axis_tlast,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [psbb_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  logic [4:0] pend_q, pend_d;
  logic       s_fire, m_fire;

  assign s_fire = s_axis_tvalid & s_axis_tready & s_axis_tlast;
  assign m_fire = m_axis_tvalid & m_axis_tready;

  // Count closed scans whose box is not yet delivered
  always_comb begin
    pend_d = pend_q;
    if (s_fire && !m_fire) begin
      pend_d = pend_q + 1'b1;
    end else if (!s_fire && m_fire) begin
      pend_d = pend_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Emit a box only for a closed scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 5'd0)
    else $error("box emitted without a last sample");

  // Keep padded edges ordered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[31:0]) <= $signed(m_axis_tdata[63:32])) &&
                      ($signed(m_axis_tdata[95:64]) <= $signed(m_axis_tdata[127:96])))
    else $error("box edges out of order");

  // Stay open to input while the output drains
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready && $past(m_axis_tready) |-> s_axis_tready)
    else $error("input blocked while output drains");

endmodule

bind polar_scan_bounding_box_core psbb_checker u_psbb_checker (.*);

// ===== sim/polar_scan_bounding_box_core_tb.sv =====
// Self-checking testbench of the polar scan bounding box core: a directed
// table, then random scans under three idling mixes, checked by a local model.
// Depends on psbb_pkg and polar_scan_bounding_box_core.
`timescale 1ns / 100ps

module polar_scan_bounding_box_core_tb;

  // Degree-9 series coefficients, Q30
  localparam longint unsigned SER_C1 = 64'd1686629713;
  localparam longint unsigned SER_C3 = 64'd693598668;
  localparam longint unsigned SER_C5 = 64'd85569306;
  localparam longint unsigned SER_C7 = 64'd5026995;
  localparam longint unsigned SER_C9 = 64'd172272;

  typedef struct packed {
    logic signed [psbb_pkg::COORD_W-1:0] max_y;
    logic signed [psbb_pkg::COORD_W-1:0] min_y;
    logic signed [psbb_pkg::COORD_W-1:0] max_x;
    logic signed [psbb_pkg::COORD_W-1:0] min_x;
  } box_t;

  typedef struct {
    logic [psbb_pkg::RANGE_BITS-1:0] range;
    bit                              last;
    bit                              typed;
    box_t                            tbox;
  } sample_t;

  typedef enum {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  typedef struct {
    row_kind_e                      kind;
    logic [psbb_pkg::CFG_IDX_W-1:0] idx;
    logic [psbb_pkg::COORD_W-1:0]   value;
    sample_t                        smp;
  } row_t;

  logic                              clk_i         = 1'b0;
  logic                              rst_ni        = 1'b0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [psbb_pkg::IN_DATA_W-1:0]    s_axis_tdata  = '0;   // [23:0] range_sample
  logic                              s_axis_tlast  = 1'b0; // last_sample
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  // [31:0] box_min_x, [63:32] box_max_x, [95:64] box_min_y, [127:96] box_max_y
  logic [psbb_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
  logic                              cfg_we_i      = 1'b0;
  logic [psbb_pkg::CFG_IDX_W-1:0]    cfg_idx_i     = '0;
  logic [psbb_pkg::COORD_W-1:0]      cfg_wdata_i   = '0;

  // Model copy of the registers
  logic signed [psbb_pkg::COORD_W-1:0] cfg_base_x = '0;
  logic signed [psbb_pkg::COORD_W-1:0] cfg_base_y = '0;
  logic [psbb_pkg::HEAD_W-1:0]         cfg_start_heading = '0;
  logic [psbb_pkg::HEAD_W-1:0]         cfg_angle_step = '0;
  logic [psbb_pkg::PAD_W-1:0]          cfg_padding = psbb_pkg::PADDING_RESET;

  // Model copy of the scan state
  logic [psbb_pkg::HEAD_W-1:0]         run_heading = '0;
  logic signed [psbb_pkg::COORD_W-1:0] lo_x = '0, hi_x = '0, lo_y = '0, hi_y = '0;
  bit                                  scan_active = 1'b0;

  sample_t sample_fifo[$];
  box_t    box_fifo[$];
  row_t    dir_rows[$];
  sample_t cur_sample;
  bit      item_taken = 1'b0;
  int      pushed_count = 0;
  int      accepted_count = 0;
  int      fail_count = 0;
  int      report_count = 0;
  int      src_idle_pct = 0;
  int      sink_stall_pct = 0;

  polar_scan_bounding_box_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Quarter-wave sine magnitude in Q16 for u in 0..16384
  function automatic logic [psbb_pkg::MAG_W-1:0] quarter_mag(
    input logic [psbb_pkg::U_W-1:0] u
  );
    longint unsigned x, x2, t, r;
    x  = {49'd0, u} << 16;
    x2 = (x * x) >> 30;
    t  = SER_C9;
    t  = SER_C7 - ((x2 * t) >> 30);
    t  = SER_C5 - ((x2 * t) >> 30);
    t  = SER_C3 - ((x2 * t) >> 30);
    t  = SER_C1 - ((x2 * t) >> 30);
    r  = (x * t) >> 30;
    r  = (r + 64'd8192) >> 14;
    if (r > 64'd65536) r = 64'd65536;
    return r[psbb_pkg::MAG_W-1:0];
  endfunction

  // Fold the angle into a quadrant, return magnitude and sign
  function automatic logic [psbb_pkg::MAG_W-1:0] sine_mag(
    input logic [psbb_pkg::HEAD_W-1:0] h, output bit neg
  );
    logic [psbb_pkg::U_W-1:0] frac;
    frac = {1'b0, h[13:0]};
    neg  = h[15];
    if (h[14]) return quarter_mag(psbb_pkg::QUARTER - frac);
    return quarter_mag(frac);
  endfunction

  // Range times magnitude, rounded half away from zero to Q16
  function automatic longint scaled_offset(input logic [psbb_pkg::RANGE_BITS-1:0] rng,
                                           input logic [psbb_pkg::MAG_W-1:0] mag,
                                           input bit neg);
    longint unsigned p;
    p = (longint'(rng) * longint'(mag) + 64'd32768) >> 16;
    return neg ? -longint'(p) : longint'(p);
  endfunction

  function automatic logic signed [psbb_pkg::COORD_W-1:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[psbb_pkg::COORD_W-1:0];
  endfunction

  // Advance the scan by one sample; returns 1 when a box closes
  function automatic bit predict_box(input logic [psbb_pkg::RANGE_BITS-1:0] rng,
                                     input bit last, output box_t b);
    logic [psbb_pkg::HEAD_W-1:0]         h, hc;
    logic [psbb_pkg::MAG_W-1:0]          cmag, smag;
    bit                                  cneg, sneg;
    logic signed [psbb_pkg::COORD_W-1:0] px, py;
    b = '0;
    if (!scan_active) begin
      run_heading = cfg_start_heading;
      lo_x = cfg_base_x;
      hi_x = cfg_base_x;
      lo_y = cfg_base_y;
      hi_y = cfg_base_y;
    end
    h    = run_heading & psbb_pkg::HEAD_MASK;
    hc   = h + psbb_pkg::QUARTER_TURN;
    cmag = sine_mag(hc, cneg);
    smag = sine_mag(h, sneg);
    px   = clamp32(longint'(cfg_base_x) + scaled_offset(rng, cmag, cneg));
    py   = clamp32(longint'(cfg_base_y) + scaled_offset(rng, smag, sneg));
    if (px < lo_x) lo_x = px;
    if (px > hi_x) hi_x = px;
    if (py < lo_y) lo_y = py;
    if (py > hi_y) hi_y = py;
    run_heading = run_heading + cfg_angle_step;
    if (!last) begin
      scan_active = 1'b1;
      return 1'b0;
    end
    scan_active = 1'b0;
    b.min_x = clamp32(longint'(lo_x) - longint'(cfg_padding));
    b.max_x = clamp32(longint'(hi_x) + longint'(cfg_padding));
    b.min_y = clamp32(longint'(lo_y) - longint'(cfg_padding));
    b.max_y = clamp32(longint'(hi_y) + longint'(cfg_padding));
    return 1'b1;
  endfunction

  function automatic logic [psbb_pkg::COORD_W-1:0] rand_coord();
    case ($urandom_range(4))
      0: return $urandom;
      1: return 32'h7FFF_FFFF - $urandom_range(32'h01FF_FFFF);
      2: return 32'h8000_0000 + $urandom_range(32'h01FF_FFFF);
      3: return $urandom_range(32'h003F_FFFF) - 32'h0020_0000;
      default: return '0;
    endcase
  endfunction

  function automatic logic [psbb_pkg::RANGE_BITS-1:0] rand_range();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2, 3: return psbb_pkg::RANGE_BITS'($urandom);
      default: return psbb_pkg::RANGE_BITS'($urandom_range(24'h03_FFFF));
    endcase
  endfunction

  // Write one register at the falling edge and mirror it in the model
  task automatic write_reg(input logic [psbb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [psbb_pkg::COORD_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      psbb_pkg::REG_BASE_X:        cfg_base_x = val;
      psbb_pkg::REG_BASE_Y:        cfg_base_y = val;
      psbb_pkg::REG_START_HEADING: cfg_start_heading = val[psbb_pkg::HEAD_W-1:0];
      psbb_pkg::REG_ANGLE_STEP:    cfg_angle_step = val[psbb_pkg::HEAD_W-1:0];
      psbb_pkg::REG_PADDING:       cfg_padding = val[psbb_pkg::PAD_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait until every queued item is taken and every box is out, then let it settle
  task automatic settle_block();
    int waited;
    waited = 0;
    wait (accepted_count == pushed_count);
    while (box_fifo.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (20) @(posedge clk_i);
    if (box_fifo.size() != 0) begin
      if (report_count < 10) $display("missing boxes: %0d still expected", box_fifo.size());
      report_count++;
      fail_count += box_fifo.size();
      box_fifo.delete();
    end
  endtask

  task automatic queue_sample(input logic [psbb_pkg::RANGE_BITS-1:0] rng, input bit last);
    sample_t s;
    s.range = rng;
    s.last  = last;
    s.typed = 1'b0;
    s.tbox  = '0;
    sample_fifo.push_back(s);
    pushed_count++;
  endtask

  task automatic add_sample(input logic [psbb_pkg::RANGE_BITS-1:0] rng, input bit last,
                            input bit typed = 1'b0, input box_t tbox = '0);
    row_t r;
    r.kind      = ROW_SAMPLE;
    r.idx       = '0;
    r.value     = '0;
    r.smp.range = rng;
    r.smp.last  = last;
    r.smp.typed = typed;
    r.smp.tbox  = tbox;
    dir_rows.push_back(r);
  endtask

  task automatic add_write(input logic [psbb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [psbb_pkg::COORD_W-1:0] val);
    row_t r;
    r.kind  = ROW_WRITE;
    r.idx   = idx;
    r.value = val;
    r.smp   = '{default: '0};
    dir_rows.push_back(r);
  endtask

  // Drive samples and the sink ready at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || item_taken) begin
        item_taken = 1'b0;
        if (sample_fifo.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          cur_sample = sample_fifo.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= psbb_pkg::IN_DATA_W'(cur_sample.range);
          s_axis_tlast  <= cur_sample.last;
        end else begin
          s_axis_tvalid <= 1'b0;
          s_axis_tdata  <= '0;
          s_axis_tlast  <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Predict on accepted samples, check accepted boxes
  always @(posedge clk_i) begin
    box_t want, got, pred;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        item_taken = 1'b1;
        accepted_count++;
        if (predict_box(cur_sample.range, cur_sample.last, pred))
          box_fifo.push_back(cur_sample.typed ? cur_sample.tbox : pred);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (box_fifo.size() == 0) begin
          if (report_count < 10) $display("unexpected box min_x=%0d", got.min_x);
          report_count++;
          fail_count++;
        end else begin
          want = box_fifo.pop_front();
          if (got.min_x !== want.min_x || got.max_x !== want.max_x ||
              got.min_y !== want.min_y || got.max_y !== want.max_y) begin
            if (report_count < 10)
              $display("box mismatch: exp x[%0d..%0d] y[%0d..%0d] got x[%0d..%0d] y[%0d..%0d]",
                       want.min_x, want.max_x, want.min_y, want.max_y,
                       got.min_x, got.max_x, got.min_y, got.max_y);
            report_count++;
            fail_count++;
          end
        end
      end
    end
  end

  // Stimulus: reset, directed table, random phases, drain
  initial begin : stimulus
    int   n, len;
    box_t tb;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    src_idle_pct   = 17;
    sink_stall_pct = 45;

    // Reset defaults: zero range closes at the base point plus half a metre
    tb = '{min_x: -32'sd32768, max_x: 32'sd32768, min_y: -32'sd32768, max_y: 32'sd32768};
    add_sample(24'h00_0000, 1'b1, 1'b1, tb);
    add_sample(24'hFF_FFFF, 1'b1);
    // Quarter-turn steps around the compass
    add_write(psbb_pkg::REG_ANGLE_STEP, 32'h0000_4000);
    add_sample(24'h01_0000, 1'b0);
    add_sample(24'h01_0000, 1'b0);
    add_sample(24'h01_0000, 1'b0);
    add_sample(24'h01_0000, 1'b1);
    // Heading wrap from the top of the circle
    add_write(psbb_pkg::REG_START_HEADING, 32'h0000_FFFF);
    add_write(psbb_pkg::REG_ANGLE_STEP, 32'h0000_7FFF);
    add_sample(24'hFF_FFFF, 1'b0);
    add_sample(24'hFF_FFFF, 1'b0);
    add_sample(24'hFF_FFFF, 1'b1);
    // Base at the coordinate corners with full padding: edges saturate
    add_write(psbb_pkg::REG_BASE_X, 32'h7FFF_FFFF);
    add_write(psbb_pkg::REG_BASE_Y, 32'h8000_0000);
    add_write(psbb_pkg::REG_PADDING, 32'h000F_FFFF);
    add_write(psbb_pkg::REG_ANGLE_STEP, 32'h0000_0000);
    add_write(psbb_pkg::REG_START_HEADING, 32'h0000_0000);
    tb = '{min_x: 32'sh7FF0_0000, max_x: 32'sh7FFF_FFFF,
           min_y: 32'sh8000_0000, max_y: 32'sh800F_FFFF};
    add_sample(24'h00_0000, 1'b1, 1'b1, tb);
    add_sample(24'hFF_FFFF, 1'b1);
    add_write(psbb_pkg::REG_START_HEADING, 32'h0000_C000);
    add_sample(24'hFF_FFFF, 1'b1);
    add_write(psbb_pkg::REG_START_HEADING, 32'h0000_8000);
    add_sample(24'hFF_FFFF, 1'b1);
    // Registers rewritten while a scan is open
    add_write(psbb_pkg::REG_BASE_X, 32'h0000_0000);
    add_write(psbb_pkg::REG_BASE_Y, 32'h0000_0000);
    add_write(psbb_pkg::REG_PADDING, 32'h0000_0000);
    add_write(psbb_pkg::REG_ANGLE_STEP, 32'h0000_8000);
    add_write(psbb_pkg::REG_START_HEADING, 32'h0000_2000);
    add_sample(24'h12_3456, 1'b0);
    add_sample(24'h00_0001, 1'b0);
    add_sample(24'hAB_CDEF, 1'b0);
    add_write(psbb_pkg::REG_BASE_X, 32'h0001_0000);
    add_write(psbb_pkg::REG_ANGLE_STEP, 32'h0000_0001);
    add_write(psbb_pkg::REG_PADDING, 32'h0000_0100);
    add_write(psbb_pkg::REG_START_HEADING, 32'h0000_1234);
    add_sample(24'h02_0000, 1'b0);
    add_sample(24'h00_FFFF, 1'b1);
    add_sample(24'h01_8000, 1'b0);
    add_sample(24'h7F_FFFF, 1'b1);

    // Walk the table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        settle_block();
        write_reg(dir_rows[i].idx, dir_rows[i].value);
      end else begin
        sample_fifo.push_back(dir_rows[i].smp);
        pushed_count++;
      end
    end

    // Random scans: two phases per idling mix
    for (int p = 0; p < 6; p++) begin
      settle_block();
      case (p / 2)
        0: begin src_idle_pct = 17; sink_stall_pct = 45; end
        1: begin src_idle_pct = 45; sink_stall_pct = 17; end
        default: begin src_idle_pct = 0; sink_stall_pct = 0; end
      endcase
      write_reg(psbb_pkg::REG_BASE_X, rand_coord());
      write_reg(psbb_pkg::REG_BASE_Y, rand_coord());
      write_reg(psbb_pkg::REG_START_HEADING, $urandom_range(16'hFFFF));
      case ($urandom_range(4))
        0: write_reg(psbb_pkg::REG_ANGLE_STEP, 32'h0000_0000);
        1: write_reg(psbb_pkg::REG_ANGLE_STEP, 32'h0000_8000);
        2: write_reg(psbb_pkg::REG_ANGLE_STEP, 32'h0000_7FFF);
        3: write_reg(psbb_pkg::REG_ANGLE_STEP, $urandom_range(16'hFFFF));
        default: write_reg(psbb_pkg::REG_ANGLE_STEP, $urandom_range(64) - 32);
      endcase
      case ($urandom_range(3))
        0: write_reg(psbb_pkg::REG_PADDING, 32'h0000_0000);
        1: write_reg(psbb_pkg::REG_PADDING, 32'h000F_FFFF);
        default: write_reg(psbb_pkg::REG_PADDING, $urandom_range(20'hF_FFFF));
      endcase
      n = 0;
      while (n < 265) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(6, 1);
        for (int k = 0; k < len; k++) queue_sample(rand_range(), k == len - 1);
        n += len;
      end
      // Sometimes leave a scan open across the next register update
      if ($urandom_range(3) == 0) begin
        len = $urandom_range(3, 1);
        for (int k = 0; k < len; k++) queue_sample(rand_range(), 1'b0);
      end
    end

    settle_block();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin : watchdog
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
design/psbb_pkg.sv
design/psbb_front.sv
design/psbb_queue.sv
design/psbb_back.sv
design/polar_scan_bounding_box_core.sv
design/psbb_checker.sv
sim/polar_scan_bounding_box_core_tb.sv
